// ===== sv/bbrm_pkg.sv =====
// ----------------------------------------------------------------------------
// Buddy block release/merge package
// Shared constants, command codes and sequencer states.
// ----------------------------------------------------------------------------
package bbrm_pkg;

  localparam int NumOrdersDef = 10;
  localparam int AddrBitsDef  = 10;

  localparam int CmdW   = 2;
  localparam int OrderW = 4;
  localparam int AddrW  = 10;

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_QUERY   = 2'd2,
    CMD_BAD     = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_TEST,
    ST_MARK,
    ST_QREAD,
    ST_QWAIT,
    ST_RESP
  } state_e;

endpackage

// ===== sv/bbrm_map.sv =====
// ----------------------------------------------------------------------------
// Buddy free map
// Single-port bit memory with registered read and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module bbrm_map import bbrm_pkg::*; #(
  parameter int ADDR_BITS = AddrBitsDef,
  localparam int MapIdxW  = ADDR_BITS + 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               we_i,
  input  logic [MapIdxW-1:0] idx_i,
  input  logic               wdata_i,
  output logic               rdata_o,
  output logic               clearing_o
);

  localparam int MapDepth = 2 ** MapIdxW;

  logic               map_mem_q [MapDepth];
  logic               rdata_q;
  logic [MapIdxW-1:0] clr_q, clr_d;
  logic               clearing_q, clearing_d;

  always_comb begin
    clr_d      = clr_q;
    clearing_d = clearing_q;
    if (clearing_q) begin
      clr_d = clr_q + MapIdxW'(1);
      if (clr_q == '1) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clearing_q <= 1'b1;
    end else begin
      clr_q      <= clr_d;
      clearing_q <= clearing_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      map_mem_q[clr_q] <= 1'b0;
    end else if (we_i) begin
      map_mem_q[idx_i] <= wdata_i;
    end
    rdata_q <= map_mem_q[idx_i];
  end

  assign rdata_o    = rdata_q;
  assign clearing_o = clearing_q;

endmodule

// ===== sv/buddy_block_release_merge_unit.sv =====
// ----------------------------------------------------------------------------
// Buddy block release/merge unit
// Loads, releases (with buddy merging) and queries blocks in a free map.
// ----------------------------------------------------------------------------
// An error goes straight to the response, a load marks the block and responds, a
// query reads the map, waits for the registered bit and responds. A release probes
// the buddy, tests and clears it per merge and probes again, then marks the block
// (no test once merging reaches the top order); each merge is one free-map read
// and one write on the single map port. The next start beat is taken in the cycle
// after the done strobe. Reset clears the map, busy high; results never stall.
module buddy_block_release_merge_unit import bbrm_pkg::*; #(
  parameter int NUM_ORDERS = NumOrdersDef,
  parameter int ADDR_BITS  = AddrBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [CmdW-1:0]   cmd_i,
  input  logic [OrderW-1:0] order_i,
  input  logic [AddrW-1:0]  address_i,
  output logic              done_o,
  output logic              status_o,
  output logic [OrderW-1:0] final_order_o,
  output logic [AddrW-1:0]  final_address_o,
  output logic              is_free_o
);

  localparam int MapIdxW = ADDR_BITS + 1;
  localparam int KW      = (NUM_ORDERS > 2) ? $clog2(NUM_ORDERS) : 1;
  localparam int CalcW   = (MapIdxW + 1 > AddrW) ? MapIdxW + 1 : AddrW;
  localparam logic [CalcW-1:0] MapBits = CalcW'(1) << MapIdxW;

  // Order k occupies 2^(ADDR_BITS-k) bits starting after all lower orders.
  function automatic logic [MapIdxW-1:0] map_index(input logic [KW-1:0] k,
                                                   input logic [AddrW-1:0] a);
    logic [CalcW-1:0] base;
    logic [CalcW-1:0] off;
    base = MapBits - (MapBits >> k);
    off  = CalcW'(a) >> k;
    return MapIdxW'(base + off);
  endfunction

  state_e             state_q, state_d;
  logic [KW-1:0]      k_q, k_d;
  logic [AddrW-1:0]   a_q, a_d;
  logic               err_q, err_d;
  logic               free_q, free_d;

  logic               map_we;
  logic               map_wdata;
  logic [MapIdxW-1:0] map_idx;
  logic [MapIdxW-1:0] self_idx;
  logic               map_rdata;
  logic               map_clearing;
  logic               accept;
  logic               in_err;
  logic               can_merge;
  cmd_e               cmd;

  assign cmd      = cmd_e'(cmd_i);
  assign accept   = start && !busy;
  assign self_idx = map_index(k_q, a_q);

  // The buddy of a block sits next to it in the map: flip the lowest index bit.
  assign can_merge = ((32'(k_q) + 1) < NUM_ORDERS) && (32'(k_q) < ADDR_BITS);

  always_comb begin
    in_err = 1'b0;
    if (cmd == CMD_BAD) begin
      in_err = 1'b1;
    end
    if (32'(order_i) >= NUM_ORDERS || 32'(order_i) > ADDR_BITS) begin
      in_err = 1'b1;
    end
    if ((CalcW'(address_i) >> ADDR_BITS) != '0) begin
      in_err = 1'b1;
    end
    if ((address_i & ~({AddrW{1'b1}} << order_i)) != '0) begin
      in_err = 1'b1;
    end
  end

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    a_d       = a_q;
    err_d     = err_q;
    free_d    = free_q;
    map_we    = 1'b0;
    map_wdata = 1'b0;
    map_idx   = self_idx;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          free_d = 1'b0;
          err_d  = in_err;
          k_d    = KW'(order_i);
          a_d    = address_i;
          if (in_err) begin
            k_d     = '0;
            a_d     = '0;
            state_d = ST_RESP;
          end else begin
            unique case (cmd)
              CMD_LOAD:    state_d = ST_MARK;
              CMD_RELEASE: state_d = ST_PROBE;
              CMD_QUERY:   state_d = ST_QREAD;
              default:     state_d = ST_RESP;
            endcase
          end
        end
      end
      ST_PROBE: begin
        map_idx = self_idx ^ MapIdxW'(1);
        state_d = can_merge ? ST_TEST : ST_MARK;
      end
      ST_TEST: begin
        map_idx = self_idx ^ MapIdxW'(1);
        if (map_rdata) begin
          map_we    = 1'b1;
          map_wdata = 1'b0;
          a_d       = a_q & ~(AddrW'(1) << k_q);
          k_d       = k_q + KW'(1);
          state_d   = ST_PROBE;
        end else begin
          state_d = ST_MARK;
        end
      end
      ST_MARK: begin
        map_we    = 1'b1;
        map_wdata = 1'b1;
        state_d   = ST_RESP;
      end
      ST_QREAD: begin
        state_d = ST_QWAIT;
      end
      ST_QWAIT: begin
        free_d  = map_rdata;
        state_d = ST_RESP;
      end
      ST_RESP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    a_q    <= a_d;
    err_q  <= err_d;
    free_q <= free_d;
  end

  bbrm_map #(
    .ADDR_BITS(ADDR_BITS)
  ) u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (map_we),
    .idx_i     (map_idx),
    .wdata_i   (map_wdata),
    .rdata_o   (map_rdata),
    .clearing_o(map_clearing)
  );

  assign busy            = (state_q != ST_IDLE) || map_clearing;
  assign done_o          = (state_q == ST_RESP);
  assign status_o        = err_q;
  assign final_order_o   = OrderW'(k_q);
  assign final_address_o = a_q;
  assign is_free_o       = free_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted beat did not raise busy");

  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy && !done_o)
    else $error("unit did not return to idle after a result");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o |-> final_order_o == '0 && final_address_o == '0 && !is_free_o)
    else $error("error result carries nonzero fields");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_we |-> state_q == ST_TEST || state_q == ST_MARK)
    else $error("free map written outside a write step");

endmodule
